/* rtl/spq_pkg.sv */
// Package for the stable priority queue: sizes, operation and status codes,
// and the request, response, entry and control structs.
// No dependencies; every file of the block imports it.
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int TAG_BITS  = 8;
	localparam int PRIO_BITS = 8;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	typedef enum logic [0:0] {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} spq_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		spq_kind_t              kind;
		logic [TAG_BITS-1:0]    item_tag;
		logic [PRIO_BITS-1:0]   item_priority;
	} spq_req_t;

	typedef struct packed {
		spq_status_t            status;
		logic [TAG_BITS-1:0]    out_tag;
		logic [PRIO_BITS-1:0]   out_priority;
		logic [CNT_BITS-1:0]    occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]    tag;
		logic [PRIO_BITS-1:0]   prio;
	} spq_entry_t;

	// Broadcast from the control logic to every cell.
	typedef struct packed {
		logic                   ins;
		logic                   rem;
		logic [CNT_BITS-1:0]    count;
		spq_entry_t             fresh;
	} spq_ctrl_t;

endpackage

/* rtl/spq_cell.sv */
// One slot of the sorted chain: holds a tag and priority and, on each
// operation, keeps its entry, takes the new one, or shifts from a neighbor.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  spq_ctrl_t  ctrl,
	input  logic       left_keep,
	input  spq_entry_t left_entry,
	input  spq_entry_t right_entry,
	output logic       keep,
	output spq_entry_t entry
);

	spq_entry_t entry_q;
	logic       occupied;

	assign occupied = ctrl.count > CNT_BITS'(IDX);
	// An occupied slot whose priority is not below the new one stays ahead of it.
	assign keep  = occupied && (entry_q.prio >= ctrl.fresh.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !keep) begin
			entry_q <= left_keep ? ctrl.fresh : left_entry;
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* rtl/stable_priority_queue_unit.sv */
// Stable priority queue of buffer tags, built as a chain of sorted cells.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   The req channel carries one operation per item: insert a tag with its
//   priority, or remove the head. The rsp channel returns exactly one item
//   per request with a status, the removed tag and priority (zero unless a
//   remove succeeded) and the occupancy after the operation.
//   Higher priority leaves first; equal priorities leave in arrival order.
//   An insert into a full queue is dropped with status full, a remove from
//   an empty queue returns status empty; neither changes the contents.
//   The response is registered; rsp_valid rises in the cycle after acceptance.
//   One item is accepted every cycle while req_stall is low: all cells compare
//   against the new priority in parallel and shift in the same cycle, and the
//   response register frees up as its item is taken.
//   When rsp_stall holds a waiting response, req_stall rises so no further
//   request is taken until that response leaves.
//   Reset empties the queue and clears rsp_valid; the slot contents are
//   not cleared, as they are never read beyond the occupancy.
module stable_priority_queue_unit import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output spq_rsp_t rsp
);

	logic [CNT_BITS-1:0] count_q;
	logic                rsp_valid_q;
	spq_rsp_t            rsp_q;
	logic                accept;
	logic                is_full;
	logic                is_empty;
	spq_ctrl_t           ctrl;
	logic                keep  [DEPTH];
	spq_entry_t          entry [DEPTH];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign is_full   = count_q == CNT_BITS'(DEPTH);
	assign is_empty  = count_q == '0;

	always_comb begin
		ctrl.ins        = accept && (req.kind == KIND_INSERT) && !is_full;
		ctrl.rem        = accept && (req.kind == KIND_REMOVE) && !is_empty;
		ctrl.count      = count_q;
		ctrl.fresh.tag  = req.item_tag;
		ctrl.fresh.prio = req.item_priority;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
			.left_entry (entry[(i == 0) ? 0 : i - 1]),
			.right_entry(entry[(i == DEPTH - 1) ? i : i + 1]),
			.keep       (keep[i]),
			.entry      (entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctrl.ins) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (ctrl.rem) begin
				count_q <= count_q - CNT_BITS'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.kind == KIND_INSERT) begin
				rsp_q.out_tag      <= '0;
				rsp_q.out_priority <= '0;
				if (is_full) begin
					rsp_q.status    <= ST_FULL;
					rsp_q.occupancy <= count_q;
				end else begin
					rsp_q.status    <= ST_OK;
					rsp_q.occupancy <= count_q + CNT_BITS'(1);
				end
			end else if (is_empty) begin
				rsp_q.status       <= ST_EMPTY;
				rsp_q.out_tag      <= '0;
				rsp_q.out_priority <= '0;
				rsp_q.occupancy    <= count_q;
			end else begin
				rsp_q.status       <= ST_OK;
				rsp_q.out_tag      <= entry[0].tag;
				rsp_q.out_priority <= entry[0].prio;
				rsp_q.occupancy    <= count_q - CNT_BITS'(1);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
